FILE: rtl/core/skr_pkg.sv
package skr_pkg;

    localparam int KEY_W      = 8;
    localparam int SLOT_STORE = 6;
    localparam int PACK_W     = $clog2(SLOT_STORE + 1);
    localparam int MOD_W      = 8;
    localparam int LED_W      = 3;

    // event kinds carried on s_tuser
    localparam logic [1:0] FUNC_KEY     = 2'd0;
    localparam logic [1:0] FUNC_MOD_SET = 2'd1;
    localparam logic [1:0] FUNC_MOD_CLR = 2'd2;

    localparam logic [KEY_W-1:0] KEY_NUM_LOCK    = 8'h53;
    localparam logic [KEY_W-1:0] KEY_CAPS_LOCK   = 8'h39;
    localparam logic [KEY_W-1:0] KEY_SCROLL_LOCK = 8'h47;

    localparam int LED_NUM    = 0;
    localparam int LED_CAPS   = 1;
    localparam int LED_SCROLL = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INSERT,
        ST_PACK,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic             start;
        logic             key_op;
        logic             press;
        logic [KEY_W-1:0] code;
    } table_cmd_t;

    typedef struct packed {
        logic idle;
        logic done;
    } table_status_t;

    typedef struct packed {
        logic eq;
        logic empty;
    } match_t;

endpackage

FILE: rtl/core/skr_match.sv
module skr_match
    import skr_pkg::*;
(
    input  logic [KEY_W-1:0] slot_key,
    input  logic [KEY_W-1:0] probe_key,
    output match_t           match
);

    assign match.eq    = (slot_key == probe_key);
    assign match.empty = (slot_key == '0);

endmodule

FILE: rtl/core/skr_table.sv
module skr_table
    import skr_pkg::*;
#(
    parameter int ROLLOVER_SLOTS = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  table_cmd_t       cmd,
    input  logic             ack,
    output table_status_t    status,
    output logic [KEY_W-1:0] keys [SLOT_STORE]
);

    localparam int IDX_W = (ROLLOVER_SLOTS > 1) ? $clog2(ROLLOVER_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROLLOVER_SLOTS - 1);

    seq_state_t       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] empty_idx_reg, empty_idx_next;
    logic             hit_reg, hit_next;
    logic             found_reg, found_next;
    logic [KEY_W-1:0] code_reg;
    logic             press_reg;
    logic [PACK_W-1:0] cnt_reg, cnt_next;

    logic [KEY_W-1:0] slot_reg [ROLLOVER_SLOTS];
    logic [KEY_W-1:0] pack_reg [SLOT_STORE];

    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [KEY_W-1:0] wr_data;
    logic             pack_clr;
    logic             pack_wr;

    logic [KEY_W-1:0] rd_key;
    match_t           match;

    assign rd_key = slot_reg[idx_reg];

    skr_match u_match (
        .slot_key  (rd_key),
        .probe_key (code_reg),
        .match     (match)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            hit_reg   <= 1'b0;
            found_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            hit_reg   <= hit_next;
            found_reg <= found_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        empty_idx_reg <= empty_idx_next;
        if (cmd.start) begin
            code_reg  <= cmd.code;
            press_reg <= cmd.press;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ROLLOVER_SLOTS; i++) begin
                slot_reg[i] <= '0;
            end
        end else if (wr_en) begin
            slot_reg[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (pack_clr) begin
            for (int i = 0; i < SLOT_STORE; i++) begin
                pack_reg[i] <= '0;
            end
        end else if (pack_wr) begin
            pack_reg[cnt_reg] <= rd_key;
        end
    end

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        empty_idx_next = empty_idx_reg;
        hit_next       = hit_reg;
        found_next     = found_reg;
        cnt_next       = cnt_reg;
        wr_en          = 1'b0;
        wr_idx         = idx_reg;
        wr_data        = '0;
        pack_clr       = 1'b0;
        pack_wr        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.start) begin
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    found_next = 1'b0;
                    cnt_next   = '0;
                    pack_clr   = 1'b1;
                    state_next = cmd.key_op ? ST_SCAN : ST_PACK;
                end
            end
            ST_SCAN: begin
                if (match.eq) begin
                    hit_next = 1'b1;
                    // release drops every slot holding the code
                    wr_en    = !press_reg;
                end
                if (match.empty && !found_reg) begin
                    found_next     = 1'b1;
                    empty_idx_next = idx_reg;
                end
                if (idx_reg == LAST_IDX) begin
                    idx_next   = '0;
                    state_next = ST_INSERT;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_INSERT: begin
                // a press of a code not yet held takes the lowest empty slot
                wr_en      = press_reg && !hit_reg && found_reg;
                wr_idx     = empty_idx_reg;
                wr_data    = code_reg;
                state_next = ST_PACK;
            end
            ST_PACK: begin
                if (!match.empty) begin
                    pack_wr  = 1'b1;
                    cnt_next = cnt_reg + PACK_W'(1);
                end
                if (idx_reg == LAST_IDX) begin
                    idx_next   = '0;
                    state_next = ST_DONE;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_DONE: begin
                if (ack) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign status.idle = (state_reg == ST_IDLE);
    assign status.done = (state_reg == ST_DONE);

    always_comb begin
        for (int i = 0; i < SLOT_STORE; i++) begin
            keys[i] = pack_reg[i];
        end
    end

endmodule

FILE: rtl/core/six_key_rollover_report_core.sv
// Keyboard report engine with a rollover table of ROLLOVER_SLOTS key slots.
// Each input word is one event (key press or release, modifier set or clear)
// and yields exactly one report word: the held keys compacted in slot order
// and padded with zeros, then the modifier byte and the three lock LED bits.
// A single comparator walks the table one slot per cycle: a key event with a
// nonzero code runs a scan pass, an insert step, a pack pass, the result load
// in ST_DONE and the idle state before the next acceptance; any other event
// skips the scan pass and the insert step. s_tready is low while an event is in
// progress; a finished report waits in ST_DONE until the output register is free.
module six_key_rollover_report_core
    import skr_pkg::*;
#(
    parameter int ROLLOVER_SLOTS = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // key_code[7:0], pressed[8], mod_mask[16:9], zero pad
    input  logic [1:0]  s_tuser,  // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata   // report_key_0..5 [47:0], report_modifiers [55:48],
                                  // report_leds [58:56], zero pad
);

    logic [KEY_W-1:0] in_code;
    logic             in_pressed;
    logic [MOD_W-1:0] in_mask;
    logic             accept;
    logic             ack;

    logic [MOD_W-1:0] mod_reg, mod_next;
    logic [LED_W-1:0] led_reg, led_next;
    logic             m_tvalid_reg;
    logic [63:0]      m_tdata_reg;

    table_cmd_t       cmd;
    table_status_t    status;
    logic [KEY_W-1:0] keys [SLOT_STORE];

    assign in_code    = s_tdata[7:0];
    assign in_pressed = s_tdata[8];
    assign in_mask    = s_tdata[16:9];

    assign s_tready = status.idle;
    assign accept   = s_tvalid && s_tready;
    assign ack      = status.done && (!m_tvalid_reg || m_tready);

    assign cmd.start  = accept;
    assign cmd.key_op = (s_tuser == FUNC_KEY) && (in_code != '0);
    assign cmd.press  = in_pressed;
    assign cmd.code   = in_code;

    skr_table #(
        .ROLLOVER_SLOTS (ROLLOVER_SLOTS)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .ack     (ack),
        .status  (status),
        .keys    (keys)
    );

    always_comb begin
        mod_next = mod_reg;
        led_next = led_reg;
        if (accept) begin
            unique case (s_tuser)
                FUNC_KEY: begin
                    // lock keys follow the key level, no toggling
                    if (in_code == KEY_NUM_LOCK) begin
                        led_next[LED_NUM] = in_pressed;
                    end else if (in_code == KEY_CAPS_LOCK) begin
                        led_next[LED_CAPS] = in_pressed;
                    end else if (in_code == KEY_SCROLL_LOCK) begin
                        led_next[LED_SCROLL] = in_pressed;
                    end
                end
                FUNC_MOD_SET: mod_next = mod_reg | in_mask;
                FUNC_MOD_CLR: mod_next = mod_reg & ~in_mask;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg      <= '0;
            led_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            mod_reg <= mod_next;
            led_reg <= led_next;
            if (ack) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ack) begin
            m_tdata_reg <= {5'b0, led_reg, mod_reg, keys[5], keys[4], keys[3],
                            keys[2], keys[1], keys[0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: rtl/core/skr_checker.sv
module skr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // one event at a time: the table is busy right after an accepted word
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an event is in progress");

    // a stalled report holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("report changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[63:59] == 5'b0)
        else $error("report pad bits not zero");

    // compaction: no held key after an empty report position
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0]   != 8'h00 || m_tdata[15:8]  == 8'h00) &&
                     (m_tdata[15:8]  != 8'h00 || m_tdata[23:16] == 8'h00) &&
                     (m_tdata[23:16] != 8'h00 || m_tdata[31:24] == 8'h00) &&
                     (m_tdata[31:24] != 8'h00 || m_tdata[39:32] == 8'h00) &&
                     (m_tdata[39:32] != 8'h00 || m_tdata[47:40] == 8'h00))
        else $error("report keys not compacted");

endmodule

bind six_key_rollover_report_core skr_checker u_skr_checker (.*);

FILE: tb/skr_report_checker.sv
`timescale 1ns / 100ps
module skr_report_checker
    import skr_pkg::*;
#(
    parameter int ROLLOVER_SLOTS = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    output int          mismatches,
    output int          reports_due
);

    typedef struct packed {
        logic [4:0]                         pad;
        logic [LED_W-1:0]                   leds;
        logic [MOD_W-1:0]                   mods;
        logic [SLOT_STORE-1:0][KEY_W-1:0]   keys;
    } report_t;

    logic [KEY_W-1:0] held_keys [SLOT_STORE];
    logic [MOD_W-1:0] modifier_byte;
    logic [LED_W-1:0] lock_bits;
    report_t          report_q [$];
    int               reports_seen;

    task automatic report_mismatch(input string what);
        $display("report %0d: %s", reports_seen, what);
        mismatches++;
    endtask

    // Update the tracked keyboard state with one event and form its report.
    function automatic report_t track_event(input logic [1:0] kind,
                                            input logic [KEY_W-1:0] code,
                                            input logic down,
                                            input logic [MOD_W-1:0] mask);
        report_t r;
        int      k;
        bit      found;
        r     = '0;
        found = 1'b0;
        case (kind)
            FUNC_KEY: begin
                // lock keys follow the key level, they do not toggle
                if (code == KEY_NUM_LOCK)
                    lock_bits[LED_NUM] = down;
                else if (code == KEY_CAPS_LOCK)
                    lock_bits[LED_CAPS] = down;
                else if (code == KEY_SCROLL_LOCK)
                    lock_bits[LED_SCROLL] = down;
                if (code != '0) begin
                    if (down) begin
                        for (int i = 0; i < ROLLOVER_SLOTS; i++)
                            if (held_keys[i] == code)
                                found = 1'b1;
                        // take the lowest empty slot, drop the press when full
                        for (int i = 0; i < ROLLOVER_SLOTS; i++)
                            if (!found && held_keys[i] == '0) begin
                                held_keys[i] = code;
                                found = 1'b1;
                            end
                    end else begin
                        for (int i = 0; i < ROLLOVER_SLOTS; i++)
                            if (held_keys[i] == code)
                                held_keys[i] = '0;
                    end
                end
            end
            FUNC_MOD_SET: modifier_byte = modifier_byte | mask;
            FUNC_MOD_CLR: modifier_byte = modifier_byte & ~mask;
            default: ;
        endcase
        k = 0;
        for (int i = 0; i < ROLLOVER_SLOTS; i++)
            if (held_keys[i] != '0) begin
                r.keys[k] = held_keys[i];
                k++;
            end
        r.mods = modifier_byte;
        r.leds = lock_bits;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        report_t got;
        report_t want;
        if (!aresetn) begin
            for (int i = 0; i < SLOT_STORE; i++)
                held_keys[i] = '0;
            modifier_byte = '0;
            lock_bits     = '0;
            report_q.delete();
            reports_seen  = 0;
            mismatches    = 0;
            reports_due  <= 0;
        end else begin
            // check the outgoing word before queueing a new event
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (report_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected report word %016h", m_tdata));
                end else begin
                    want = report_q.pop_front();
                    for (int j = 0; j < SLOT_STORE; j++)
                        if (got.keys[j] !== want.keys[j])
                            report_mismatch($sformatf("key %0d got %02h want %02h",
                                                      j, got.keys[j], want.keys[j]));
                    if (got.mods !== want.mods)
                        report_mismatch($sformatf("modifiers got %02h want %02h",
                                                  got.mods, want.mods));
                    if (got.leds !== want.leds)
                        report_mismatch($sformatf("leds got %0h want %0h",
                                                  got.leds, want.leds));
                    if (got.pad !== want.pad)
                        report_mismatch($sformatf("pad bits got %02h, want zero", got.pad));
                end
                reports_seen++;
            end
            if (s_tvalid && s_tready)
                report_q.push_back(track_event(s_tuser, s_tdata[7:0], s_tdata[8],
                                               s_tdata[16:9]));
            reports_due <= report_q.size();
        end
    end

endmodule

FILE: tb/six_key_rollover_report_core_test.sv
`timescale 1ns / 100ps
module six_key_rollover_report_core_test;
    import skr_pkg::*;

    localparam logic [1:0] FUNC_SPARE    = 2'd3;
    localparam int         RANDOM_EVENTS = 650;
    localparam int         IDLE_LIMIT    = 4000;
    localparam int         SETTLE_CYCLES = 40;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;

    int mismatches;
    int reports_due;
    int burst_left  = 0;
    int idle_cycles = 0;
    int ready_pct   = 100;
    int pattern_left = 0;

    logic [KEY_W-1:0] key_pool [10] = '{KEY_NUM_LOCK, KEY_CAPS_LOCK, KEY_SCROLL_LOCK,
                                        8'h04, 8'h05, 8'h06, 8'h1E, 8'h2C, 8'hE0, 8'hFF};
    logic [KEY_W-1:0] stray_keys [$];

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    six_key_rollover_report_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    skr_report_checker report_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .reports_due (reports_due)
    );

    // receiver: ready probability changes from one stretch to the next
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 75;
                    2: ready_pct = 35;
                    default: ready_pct = 8;
                endcase
            end else begin
                pattern_left--;
            end
            m_tready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("six_key_rollover_report_core test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_event(input logic [1:0] kind, input logic [KEY_W-1:0] code,
                              input logic down, input logic [MOD_W-1:0] mask);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'b0, mask, down, code};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    // hold the sender until every report word has come back
    task automatic wait_drained();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (reports_due != 0) @(posedge aclk);
    endtask

    task automatic random_event();
        logic [1:0]       kind;
        logic [KEY_W-1:0] code;
        logic             down;
        int               pick;
        int               slot;
        pick = $urandom_range(0, 99);
        if (pick < 62)
            kind = FUNC_KEY;
        else if (pick < 77)
            kind = FUNC_MOD_SET;
        else if (pick < 92)
            kind = FUNC_MOD_CLR;
        else
            kind = FUNC_SPARE;
        down = ($urandom_range(0, 99) < 55);
        pick = $urandom_range(0, 99);
        if (down) begin
            if (pick < 70) begin
                code = key_pool[$urandom_range(0, 9)];
            end else if (pick < 92) begin
                code = KEY_W'($urandom_range(0, 255));
                if (kind == FUNC_KEY && code != '0)
                    stray_keys.push_back(code);
            end else begin
                code = '0;
            end
        end else begin
            // release stray codes too, or the table stays full of them
            if (pick < 40 && stray_keys.size() != 0) begin
                slot = $urandom_range(0, stray_keys.size() - 1);
                code = stray_keys[slot];
                if (kind == FUNC_KEY)
                    stray_keys.delete(slot);
            end else if (pick < 85) begin
                code = key_pool[$urandom_range(0, 9)];
            end else if (pick < 95) begin
                code = KEY_W'($urandom_range(0, 255));
            end else begin
                code = '0;
            end
        end
        send_event(kind, code, down, MOD_W'($urandom_range(0, 255)));
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= FUNC_KEY;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        send_event(FUNC_SPARE,   8'h2A, 1'b1, 8'hFF);
        send_event(FUNC_MOD_SET, 8'hFF, 1'b1, 8'hFF);
        send_event(FUNC_MOD_CLR, 8'h00, 1'b0, 8'h0F);
        send_event(FUNC_MOD_CLR, 8'h53, 1'b1, 8'hF0);
        send_event(FUNC_MOD_SET, 8'h00, 1'b0, 8'h00);
        send_event(FUNC_KEY,     8'h00, 1'b1, 8'hFF);
        send_event(FUNC_KEY,     8'h00, 1'b0, 8'h00);
        send_event(FUNC_KEY, KEY_NUM_LOCK,    1'b1, 8'h00);
        send_event(FUNC_KEY, KEY_CAPS_LOCK,   1'b1, 8'hAA);
        send_event(FUNC_KEY, KEY_SCROLL_LOCK, 1'b1, 8'h55);
        send_event(FUNC_KEY,     8'h04, 1'b1, 8'h00);
        send_event(FUNC_KEY,     8'hFF, 1'b1, 8'h00);
        send_event(FUNC_KEY,     8'h01, 1'b1, 8'h00);
        // table full: drop this one, then a repeat press of a held key
        send_event(FUNC_KEY,     8'h80, 1'b1, 8'h00);
        send_event(FUNC_KEY,     8'h04, 1'b1, 8'h00);
        send_event(FUNC_KEY, KEY_CAPS_LOCK,   1'b0, 8'h00);
        send_event(FUNC_KEY,     8'h80, 1'b1, 8'h00);
        send_event(FUNC_KEY, KEY_NUM_LOCK,    1'b0, 8'h00);
        send_event(FUNC_KEY, KEY_SCROLL_LOCK, 1'b0, 8'h00);
        send_event(FUNC_KEY,     8'hAA, 1'b0, 8'h00);
        send_event(FUNC_KEY, KEY_CAPS_LOCK,   1'b0, 8'h00);
        send_event(FUNC_KEY,     8'h04, 1'b0, 8'h00);
        send_event(FUNC_KEY,     8'hFF, 1'b0, 8'h00);
        send_event(FUNC_KEY,     8'h01, 1'b0, 8'h00);
        send_event(FUNC_KEY,     8'h80, 1'b0, 8'h00);
        wait_drained();

        for (int n = 0; n < RANDOM_EVENTS; n++) begin
            random_event();
            if (n == RANDOM_EVENTS / 2)
                wait_drained();
        end
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0 && reports_due == 0)
            $display("six_key_rollover_report_core test passed");
        else
            $display("six_key_rollover_report_core test failed");
        $finish;
    end

endmodule
